FILE: hw/rtl/lstp_pkg.sv
package lstp_pkg;

	localparam int TableDepth = 1024;
	localparam logic [32:0] SingleRowGapUs = 33'd10000;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_SAMPLE = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK             = 2'd0,
		ST_NOT_INCREASING = 2'd1,
		ST_FULL           = 2'd2,
		ST_EMPTY          = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_CHECK,
		S_FETCH,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        row_offset_us;
		logic [63:0]        query_time_us;
		logic signed [15:0] in_accel_x;
		logic signed [15:0] in_accel_y;
		logic signed [15:0] in_accel_z;
		logic signed [15:0] in_gyro_x;
		logic signed [15:0] in_gyro_y;
		logic signed [15:0] in_gyro_z;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] out_accel_x;
		logic signed [15:0] out_accel_y;
		logic signed [15:0] out_accel_z;
		logic signed [15:0] out_gyro_x;
		logic signed [15:0] out_gyro_y;
		logic signed [15:0] out_gyro_z;
	} out_item_t;

endpackage

FILE: hw/rtl/lstp_ram.sv
module lstp_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hw/rtl/lstp_mod.sv
module lstp_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [32:0] divisor,
	output logic        done,
	output logic [32:0] remainder
);

	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] div_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [33:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q, quo_q[63]};
	assign diff = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd63) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], 1'b0};
			if (!diff[33]) begin
				rem_q <= diff[32:0];
			end else begin
				rem_q <= shifted[32:0];
			end
		end
	end

	assign done = busy_q && (cnt_q == 7'd63);
	assign remainder = diff[33] ? shifted[32:0] : diff[32:0];

endmodule

FILE: hw/rtl/looping_sample_table_playback.sv
// Looping sample table playback.
// The in channel carries one request per transfer: clear, append row or sample at time.
// The out channel returns exactly one result per request, in request order.
// A clear or append request goes straight to the out state, where its result is
// registered once the result register can take it.
// A sample request on a non-empty table runs a restoring modulo of the query time by
// the loop length, then steps the cursor through the row time memory row by row.
// It then fetches that row's axes and registers its result in the out state, and the
// next request can transfer in the cycle after that.
// One request is worked on at a time; stall is high from the transfer until the
// result has been handed on to the result register.
// The result register holds its item while the out side stalls; the next
// request is then worked on and waits only for that register to free up.
// Reset empties the table and rewinds playback; the row memories are not
// cleared, since only rows below the row count are ever used.
// Type 3 requests change nothing and return status ok with zero axes.
module looping_sample_table_playback #(
	parameter int TableDepth = lstp_pkg::TableDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lstp_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lstp_pkg::out_item_t  out_data
);

	localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CW = $clog2(TableDepth + 1);
	localparam logic [CW-1:0] DepthC = CW'(TableDepth);

	lstp_pkg::fsm_t state_q, state_d;
	lstp_pkg::in_item_t req_q;

	logic [CW-1:0] count_q;
	logic [31:0]   first_q;
	logic [31:0]   last_q;
	logic [32:0]   loop_q;
	logic [AW-1:0] cursor_q;
	logic [32:0]   prev_q;
	logic [32:0]   m_q;

	logic          out_valid_q;
	lstp_pkg::out_item_t out_q;
	lstp_pkg::out_item_t out_d;

	logic          t_we;
	logic [AW-1:0] t_waddr;
	logic [31:0]   t_wdata;
	logic [AW-1:0] t_raddr;
	logic [31:0]   t_rdata;
	logic [95:0]   a_wdata;
	logic [95:0]   a_rdata;

	logic          mod_start;
	logic          mod_done;
	logic [32:0]   mod_rem;

	logic          accept;
	logic          can_out;
	logic [32:0]   prev_abs;
	logic [31:0]   rel;
	logic [31:0]   gap;
	logic [AW-1:0] cur_start;
	logic [CW-1:0] next_idx;
	logic          step_ok;
	logic          append_ok;

	assign can_out  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != lstp_pkg::S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign prev_abs = {1'b0, first_q} + {1'b0, last_q};
	assign rel      = req_q.row_offset_us - first_q;
	assign gap      = rel - last_q;
	assign next_idx = CW'(cursor_q) + CW'(1);
	assign step_ok  = (next_idx < count_q) && ({1'b0, t_rdata} <= m_q);
	assign append_ok = (count_q < DepthC)
		&& ((count_q == '0) || ({1'b0, req_q.row_offset_us} > prev_abs));

	always_comb begin
		cur_start = cursor_q;
		if ((mod_rem < prev_q) || (CW'(cursor_q) >= count_q)) begin
			cur_start = '0;
		end
	end

	assign mod_start = (state_q == lstp_pkg::S_IDLE) && accept
		&& (lstp_pkg::req_t'(in_data.req_type) == lstp_pkg::REQ_SAMPLE)
		&& (count_q != '0) && (loop_q != '0);

	lstp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (in_data.query_time_us),
		.divisor   (loop_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lstp_pkg::S_IDLE: begin
				if (accept) begin
					state_d = mod_start ? lstp_pkg::S_DIV : lstp_pkg::S_OUT;
				end
			end
			lstp_pkg::S_DIV: begin
				if (mod_done) begin
					state_d = lstp_pkg::S_READ;
				end
			end
			lstp_pkg::S_READ:  state_d = lstp_pkg::S_CHECK;
			lstp_pkg::S_CHECK: state_d = step_ok ? lstp_pkg::S_READ : lstp_pkg::S_FETCH;
			lstp_pkg::S_FETCH: state_d = lstp_pkg::S_OUT;
			lstp_pkg::S_OUT: begin
				if (can_out) begin
					state_d = lstp_pkg::S_IDLE;
				end
			end
			default: state_d = lstp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		t_raddr = AW'(next_idx);
		if (state_q == lstp_pkg::S_FETCH || state_q == lstp_pkg::S_OUT) begin
			t_raddr = cursor_q;
		end
		t_we    = (state_q == lstp_pkg::S_OUT) && can_out
			&& (lstp_pkg::req_t'(req_q.req_type) == lstp_pkg::REQ_APPEND)
			&& append_ok;
		t_waddr = AW'(count_q);
		t_wdata = (count_q == '0) ? 32'd0 : rel;
		a_wdata = {req_q.in_accel_x, req_q.in_accel_y, req_q.in_accel_z,
			req_q.in_gyro_x, req_q.in_gyro_y, req_q.in_gyro_z};
	end

	always_comb begin
		out_d = '0;
		out_d.status = lstp_pkg::ST_OK;
		case (lstp_pkg::req_t'(req_q.req_type))
			lstp_pkg::REQ_APPEND: begin
				if (count_q >= DepthC) begin
					out_d.status = lstp_pkg::ST_FULL;
				end else if (!append_ok) begin
					out_d.status = lstp_pkg::ST_NOT_INCREASING;
				end
			end
			lstp_pkg::REQ_SAMPLE: begin
				if (count_q == '0 || loop_q == '0) begin
					out_d.status = lstp_pkg::ST_EMPTY;
				end else begin
					{out_d.out_accel_x, out_d.out_accel_y, out_d.out_accel_z,
						out_d.out_gyro_x, out_d.out_gyro_y, out_d.out_gyro_z} = a_rdata;
				end
			end
			default: ;
		endcase
	end

	lstp_ram #(.Width(32), .Depth(TableDepth)) u_time_ram (
		.clk     (clk),
		.wr_en   (t_we),
		.wr_addr (t_waddr),
		.wr_data (t_wdata),
		.rd_addr (t_raddr),
		.rd_data (t_rdata)
	);

	lstp_ram #(.Width(96), .Depth(TableDepth)) u_axes_ram (
		.clk     (clk),
		.wr_en   (t_we),
		.wr_addr (t_waddr),
		.wr_data (a_wdata),
		.rd_addr (t_raddr),
		.rd_data (a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lstp_pkg::S_IDLE;
			count_q     <= '0;
			first_q     <= '0;
			last_q      <= '0;
			loop_q      <= '0;
			cursor_q    <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lstp_pkg::S_OUT && can_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == lstp_pkg::S_DIV && mod_done) begin
				cursor_q <= cur_start;
				prev_q   <= mod_rem;
			end
			if (state_q == lstp_pkg::S_CHECK && step_ok) begin
				cursor_q <= AW'(next_idx);
			end
			if (state_q == lstp_pkg::S_OUT && can_out) begin
				case (lstp_pkg::req_t'(req_q.req_type))
					lstp_pkg::REQ_CLEAR: begin
						count_q  <= '0;
						first_q  <= '0;
						last_q   <= '0;
						loop_q   <= '0;
						cursor_q <= '0;
						prev_q   <= '0;
					end
					lstp_pkg::REQ_APPEND: begin
						if (t_we) begin
							count_q  <= count_q + CW'(1);
							cursor_q <= '0;
							prev_q   <= '0;
							if (count_q == '0) begin
								first_q <= req_q.row_offset_us;
								last_q  <= '0;
								loop_q  <= lstp_pkg::SingleRowGapUs;
							end else begin
								last_q <= rel;
								loop_q <= {1'b0, rel} + {1'b0, gap};
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		if (state_q == lstp_pkg::S_DIV && mod_done) begin
			m_q <= mod_rem;
		end
		if (state_q == lstp_pkg::S_OUT && can_out) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC) else $error("row count beyond depth");
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lstp_pkg::S_FETCH) |-> (CW'(cursor_q) < count_q))
		else $error("cursor outside table");
	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		t_we |=> (count_q == $past(count_q) + CW'(1)))
		else $error("row write without count step");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lstp_pkg::S_OUT && can_out) |=> out_valid_q)
		else $error("result lost");
`endif

endmodule

FILE: dv/playback_checker.sv
module playback_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  lstp_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  lstp_pkg::out_item_t out_data,
	output int                  fail_count,
	output int                  pending_count,
	output int                  result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] row_times [lstp_pkg::TableDepth];
	logic [95:0] row_axes [lstp_pkg::TableDepth];
	logic [10:0] rows;
	logic [31:0] base_time;
	logic [31:0] last_offset;
	logic [32:0] period;
	logic [9:0]  cursor;
	logic [32:0] last_phase;
	lstp_pkg::out_item_t awaited [$];

	function automatic lstp_pkg::out_item_t play_request(input lstp_pkg::in_item_t req);
		lstp_pkg::out_item_t res;
		logic [32:0] prev_abs;
		logic [31:0] rel;
		logic [31:0] gap;
		logic [63:0] phase;
		res = '0;
		res.status = lstp_pkg::ST_OK;
		case (lstp_pkg::req_t'(req.req_type))
			lstp_pkg::REQ_CLEAR: begin
				rows = '0;
				base_time = '0;
				last_offset = '0;
				period = '0;
				cursor = '0;
				last_phase = '0;
			end
			lstp_pkg::REQ_APPEND: begin
				prev_abs = {1'b0, base_time} + {1'b0, last_offset};
				if (rows >= lstp_pkg::TableDepth) begin
					res.status = lstp_pkg::ST_FULL;
				end else if (rows != 0 && {1'b0, req.row_offset_us} <= prev_abs) begin
					res.status = lstp_pkg::ST_NOT_INCREASING;
				end else begin
					if (rows == 0) begin
						base_time = req.row_offset_us;
						rel = '0;
						period = lstp_pkg::SingleRowGapUs;
					end else begin
						rel = req.row_offset_us - base_time;
						gap = rel - last_offset;
						period = {1'b0, rel} + {1'b0, gap};
					end
					row_times[rows[9:0]] = rel;
					row_axes[rows[9:0]] = {req.in_accel_x, req.in_accel_y, req.in_accel_z,
						req.in_gyro_x, req.in_gyro_y, req.in_gyro_z};
					rows = rows + 11'd1;
					last_offset = rel;
					cursor = '0;
					last_phase = '0;
				end
			end
			lstp_pkg::REQ_SAMPLE: begin
				if (rows == 0 || period == 0) begin
					res.status = lstp_pkg::ST_EMPTY;
				end else begin
					phase = req.query_time_us % {31'd0, period};
					if (phase[32:0] < last_phase)
						cursor = '0;
					last_phase = phase[32:0];
					if ({1'b0, cursor} >= rows)
						cursor = '0;
					while ({1'b0, cursor} + 11'd1 < rows
						&& {32'd0, row_times[cursor + 10'd1]} <= phase)
						cursor = cursor + 10'd1;
					{res.out_accel_x, res.out_accel_y, res.out_accel_z,
						res.out_gyro_x, res.out_gyro_y, res.out_gyro_z} = row_axes[cursor];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lstp_pkg::out_item_t want;
		if (!arst_n) begin
			rows = '0;
			base_time = '0;
			last_offset = '0;
			period = '0;
			cursor = '0;
			last_phase = '0;
			fail_count = 0;
			result_count = 0;
			awaited.delete();
			pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (awaited.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					want = awaited.pop_front();
					if (out_data.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, out_data.status);
						fail_count++;
					end
					if (out_data.out_accel_x !== want.out_accel_x) begin
						$error("out_accel_x expected %0d actual %0d",
							want.out_accel_x, out_data.out_accel_x);
						fail_count++;
					end
					if (out_data.out_accel_y !== want.out_accel_y) begin
						$error("out_accel_y expected %0d actual %0d",
							want.out_accel_y, out_data.out_accel_y);
						fail_count++;
					end
					if (out_data.out_accel_z !== want.out_accel_z) begin
						$error("out_accel_z expected %0d actual %0d",
							want.out_accel_z, out_data.out_accel_z);
						fail_count++;
					end
					if (out_data.out_gyro_x !== want.out_gyro_x) begin
						$error("out_gyro_x expected %0d actual %0d",
							want.out_gyro_x, out_data.out_gyro_x);
						fail_count++;
					end
					if (out_data.out_gyro_y !== want.out_gyro_y) begin
						$error("out_gyro_y expected %0d actual %0d",
							want.out_gyro_y, out_data.out_gyro_y);
						fail_count++;
					end
					if (out_data.out_gyro_z !== want.out_gyro_z) begin
						$error("out_gyro_z expected %0d actual %0d",
							want.out_gyro_z, out_data.out_gyro_z);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				awaited.insert(awaited.size(), play_request(in_data));
			pending_count = awaited.size();
		end
	end
endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	lstp_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	lstp_pkg::out_item_t out_data;
	int        fail_count;
	int        pending_count;
	int        result_count;
	bit        calm;
	logic [31:0] stamp;
	int        sent;
	int        n_clear;
	int        n_append;
	int        n_sample;

	looping_sample_table_playback dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	playback_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("FAIL looping_sample_table_playback");
		$finish;
	end

	// The out side stalls in bursts until the last part of the run.
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic lstp_pkg::in_item_t make_item(input lstp_pkg::req_t kind,
			input logic [31:0] t, input logic [63:0] q);
		lstp_pkg::in_item_t it;
		it.req_type = kind;
		it.row_offset_us = t;
		it.query_time_us = q;
		it.in_accel_x = 16'($urandom());
		it.in_accel_y = 16'($urandom());
		it.in_accel_z = 16'($urandom());
		it.in_gyro_x = 16'($urandom());
		it.in_gyro_y = 16'($urandom());
		it.in_gyro_z = 16'($urandom());
		return it;
	endfunction

	task automatic send(input lstp_pkg::in_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		case (lstp_pkg::req_t'(it.req_type))
			lstp_pkg::REQ_CLEAR: n_clear++;
			lstp_pkg::REQ_APPEND: n_append++;
			lstp_pkg::REQ_SAMPLE: n_sample++;
			default: ;
		endcase
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic fill_table(input int count, input int step_max);
		repeat (count) begin
			stamp = stamp + $urandom_range(1, step_max);
			send(make_item(lstp_pkg::REQ_APPEND, stamp, rand64()));
		end
	endtask

	initial begin
		lstp_pkg::in_item_t it;
		int kind;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		sent = 0;
		n_clear = 0;
		n_append = 0;
		n_sample = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, single row, extremes, bad time, type 3.
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, '1));
		it = make_item(lstp_pkg::REQ_NONE, '1, '1);
		send(it);
		it = make_item(lstp_pkg::REQ_APPEND, 32'hFFFF_FFF0, '0);
		it.in_accel_x = 16'sh7FFF;
		it.in_gyro_z = 16'sh8000;
		send(it);
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, 64'd0));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, '1));
		send(make_item(lstp_pkg::REQ_APPEND, 32'hFFFF_FFF0, '0));
		send(make_item(lstp_pkg::REQ_APPEND, 32'h0000_0005, '0));
		send(make_item(lstp_pkg::REQ_APPEND, 32'hFFFF_FFFF, '0));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, 64'd14));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, 64'd15));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd3, 64'd29));
		send(make_item(lstp_pkg::REQ_CLEAR, '1, '1));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, 64'd7));
		send(make_item(lstp_pkg::REQ_APPEND, 32'd0, '0));
		send(make_item(lstp_pkg::REQ_APPEND, 32'd0, '0));
		send(make_item(lstp_pkg::REQ_APPEND, 32'hFFFF_FFFF, '0));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, 64'h0000_0001_FFFF_FFFF));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, 64'h0000_0001_FFFF_FFFD));
		send(make_item(lstp_pkg::REQ_SAMPLE, 32'd0, '1));

		// One full table, then appends that must be refused as full.
		send(make_item(lstp_pkg::REQ_CLEAR, '0, '0));
		stamp = $urandom_range(0, 1000);
		send(make_item(lstp_pkg::REQ_APPEND, stamp, '0));
		fill_table(lstp_pkg::TableDepth - 1, 20);
		send(make_item(lstp_pkg::REQ_APPEND, stamp + 1, '0));
		send(make_item(lstp_pkg::REQ_APPEND, stamp, '0));
		repeat (20) send(make_item(lstp_pkg::REQ_SAMPLE, '0, rand64()));
		send(make_item(lstp_pkg::REQ_SAMPLE, '0, '1));

		// Random part: mostly short tables played forward in time.
		while (sent < 1500) begin
			if (sent > 1350)
				calm = 1'b1;
			send(make_item(lstp_pkg::REQ_CLEAR, $urandom(), rand64()));
			stamp = $urandom();
			k = $urandom_range(1, 12);
			send(make_item(lstp_pkg::REQ_APPEND, stamp, rand64()));
			for (int i = 1; i < k; i++) begin
				if ($urandom_range(0, 9) == 0)
					send(make_item(lstp_pkg::REQ_APPEND, stamp - $urandom_range(0, 3),
						rand64()));
				else
					fill_table(1, ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : 200);
			end
			for (int i = 0; i < 12; i++) begin
				kind = $urandom_range(0, 19);
				if (kind == 0)
					send(make_item(lstp_pkg::req_t'($urandom_range(0, 3)), $urandom(),
						rand64()));
				else if (kind < 4)
					send(make_item(lstp_pkg::REQ_SAMPLE, '0, rand64()));
				else
					send(make_item(lstp_pkg::REQ_SAMPLE, '0,
						64'(i) * $urandom_range(0, 300)));
			end
		end
		calm = 1'b1;
		in_valid <= 1'b0;

		k = 0;
		while (pending_count != 0 && k < 100000) begin
			@(posedge clk);
			k++;
		end
		repeat (200) @(posedge clk);
		$display("Covered %0d requests: %0d clears, %0d appends, %0d samples; %0d results.",
			sent, n_clear, n_append, n_sample, result_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS looping_sample_table_playback");
		end else begin
			$display("FAIL looping_sample_table_playback");
		end
		$finish;
	end
endmodule
